// ----- rtl/size_class_free_list_allocator_unit_defines.svh -----
// Assertion macros shared by the allocator RTL.
// Depends on nothing; the using module must have clk and arst_n in scope.
`ifndef SIZE_CLASS_FREE_LIST_ALLOCATOR_UNIT_DEFINES_SVH
`define SIZE_CLASS_FREE_LIST_ALLOCATOR_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while reset is asserted.
`define SCFA_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while reset is asserted.
`define SCFA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/scfa_pkg.sv -----
// Package of the size class free list allocator: payload structs, codes,
// sizing constants and the class lookup functions. Depends on nothing.
`default_nettype none

package scfa_pkg;

	localparam int CLASS_COUNT  = 16;
	localparam int CLASS_W      = 4;
	localparam int STACK_DEPTH  = 64;
	localparam int STACK_W      = 6;
	localparam int FILL_W       = 7;
	localparam int STORE_AW     = CLASS_W + STACK_W;
	localparam int STORE_DEPTH  = CLASS_COUNT * STACK_DEPTH;
	localparam int ADDR_W       = 40;
	localparam int SIZE_W       = 32;
	localparam int TOTAL_W      = SIZE_W + 1;
	localparam int HDR_W        = 18;
	localparam int STATUS_W     = 3;
	localparam int CFG_IDX_W    = 1;
	localparam int MIN_BLOCK    = 8;
	localparam int HEADER_BYTES = 8;
	localparam int PAGE_BYTES   = 65536;

	localparam logic [ADDR_W-1:0] HEAP_START_RST = 40'h04_0000_0000;
	localparam logic [ADDR_W-1:0] HEAP_LIMIT_RST = 40'h08_0000_0000;
	localparam logic [TOTAL_W-1:0] MAX_BLOCK =
		TOTAL_W'(64'(MIN_BLOCK) << (CLASS_COUNT - 1));

	typedef enum logic {
		OP_ALLOC = 1'b0,
		OP_FREE  = 1'b1
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK         = 3'd0,
		ST_OOM        = 3'd1,
		ST_TOO_LARGE  = 3'd2,
		ST_NULL_FREE  = 3'd3,
		ST_STACK_FULL = 3'd4
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_HEAP_START = 1'b0,
		REG_HEAP_LIMIT = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		op_t               opcode;
		logic [SIZE_W-1:0] request_size;
		logic [ADDR_W-1:0] block_address;
		logic [HDR_W-1:0]  stored_usable_size;
	} req_t;

	typedef struct packed {
		status_t            status;
		logic [ADDR_W-1:0]  user_address;
		logic [HDR_W-1:0]   header_value;
		logic [CLASS_W-1:0] size_class;
	} rsp_t;

	// Smallest class whose block holds total bytes, clamped to the last class.
	function automatic logic [CLASS_W-1:0] class_of(input logic [TOTAL_W-1:0] total);
		logic [CLASS_W-1:0] c;
		c = CLASS_W'(CLASS_COUNT - 1);
		for (int i = CLASS_COUNT - 1; i >= 0; i--) begin
			if (TOTAL_W'(64'(MIN_BLOCK) << i) >= total) begin
				c = CLASS_W'(i);
			end
		end
		return c;
	endfunction

	// Usable bytes of a block of class c.
	function automatic logic [HDR_W-1:0] usable_of(input logic [CLASS_W-1:0] c);
		return HDR_W'((64'(MIN_BLOCK) << c) - 64'(HEADER_BYTES));
	endfunction

	// Heap bytes a fresh block of class c takes: whole pages.
	function automatic logic [ADDR_W-1:0] heap_bytes_of(input logic [CLASS_W-1:0] c);
		logic [63:0] b;
		b = 64'(MIN_BLOCK) << c;
		if (b < 64'(PAGE_BYTES)) begin
			b = 64'(PAGE_BYTES);
		end
		return ADDR_W'(b);
	endfunction

endpackage

`default_nettype wire

// ----- rtl/size_class_free_list_allocator_unit.sv -----
// Top level of the size class free list allocator.
// Depends on scfa_pkg and size_class_free_list_allocator_unit_defines.svh.
`default_nettype none
`include "size_class_free_list_allocator_unit_defines.svh"

// Requests arrive on the req channel (req_valid, req_stall, req). A transfer
// happens at a rising edge with req_valid high and req_stall low. Each request
// is an allocate or a free and yields exactly one response on the rsp channel
// (rsp_valid, rsp_stall, rsp), in request order.
// A request passes through the input register and then the result register
// on its way to the response. Throughput is one request per cycle while the
// receiver does not stall; the class stacks, fill counts and bump pointer are
// updated as a request leaves the input register, so a pop that directly
// follows a push to the same class sees the pushed block without forwarding.
// The free block store is a single-port memory (one read or one write per
// cycle), which is all one request needs.
// When the receiver holds rsp_stall high, the response stays unchanged; the
// input register keeps accepting until it is full, and req_stall rises only
// while both registers hold a request and the receiver stalls.
// The cfg channel writes the heap start (index 0, which also reloads the bump
// pointer) and the heap limit (index 1); cfg_ready is always high. Write it
// only while no request is in flight. Reset (arst_n low) empties both pipeline
// registers, clears all class fill counts and loads the heap limit and bump
// pointer with their defaults. The store is not cleared: an entry is read only
// after a push.
module size_class_free_list_allocator_unit (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire                                   req_valid,
	output logic                                  req_stall,
	input  scfa_pkg::req_t                        req,
	output logic                                  rsp_valid,
	input  wire                                   rsp_stall,
	output scfa_pkg::rsp_t                        rsp,
	input  wire                                   cfg_valid,
	output logic                                  cfg_ready,
	input  wire  [scfa_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  wire  [scfa_pkg::ADDR_W-1:0]           cfg_data
);

	// Input register.
	logic                          valid_s1;
	scfa_pkg::req_t                req_s1;

	// Result register; the popped block arrives in rd_q alongside it.
	logic                          valid_s2;
	scfa_pkg::status_t             status_s2;
	logic                          addr_ok_s2;
	logic                          pop_s2;
	logic [scfa_pkg::ADDR_W-1:0]   block_s2;
	logic [scfa_pkg::HDR_W-1:0]    hdr_s2;
	logic [scfa_pkg::CLASS_W-1:0]  cls_s2;
	logic [scfa_pkg::ADDR_W-1:0]   rd_q;

	// Architectural state.
	logic [scfa_pkg::ADDR_W-1:0]   heap_limit_q;
	logic [scfa_pkg::ADDR_W-1:0]   bump_q;
	logic [scfa_pkg::FILL_W-1:0]   fill_q [scfa_pkg::CLASS_COUNT];
	logic [scfa_pkg::ADDR_W-1:0]   store_mem [scfa_pkg::STORE_DEPTH];

	// Handshake.
	logic                          s2_ready;
	logic                          adv;
	logic                          req_xfer;
	logic                          cfg_we;

	// Decision for the request in the input register.
	logic [scfa_pkg::SIZE_W-1:0]   size_eff;
	logic [scfa_pkg::TOTAL_W-1:0]  total;
	logic [scfa_pkg::CLASS_W-1:0]  cls_d;
	logic [scfa_pkg::FILL_W-1:0]   fill_sel;
	logic [scfa_pkg::ADDR_W-1:0]   bytes_d;
	scfa_pkg::status_t             status_d;
	logic                          addr_ok_d;
	logic                          pop_d;
	logic                          push_d;
	logic                          bump_d;
	logic [scfa_pkg::HDR_W-1:0]    hdr_d;
	logic [scfa_pkg::CLASS_W-1:0]  cls_out_d;
	logic [scfa_pkg::ADDR_W-1:0]   free_block;
	logic [scfa_pkg::STACK_W-1:0]  slot_d;
	logic [scfa_pkg::STORE_AW-1:0] mem_addr;
	logic [scfa_pkg::ADDR_W-1:0]   resp_block;

	assign s2_ready  = !valid_s2 || !rsp_stall;
	assign adv       = valid_s1 && s2_ready;
	assign req_stall = valid_s1 && !s2_ready;
	assign req_xfer  = req_valid && !req_stall;
	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;

	// Class selection, stack status and the heap check. An allocate of zero
	// bytes counts as one byte; a free takes its class from the header size.
	always_comb begin
		size_eff   = (req_s1.request_size == '0) ? scfa_pkg::SIZE_W'(1) : req_s1.request_size;
		free_block = req_s1.block_address - scfa_pkg::ADDR_W'(scfa_pkg::HEADER_BYTES);
		if (req_s1.opcode == scfa_pkg::OP_ALLOC) begin
			total = scfa_pkg::TOTAL_W'(size_eff) + scfa_pkg::TOTAL_W'(scfa_pkg::HEADER_BYTES);
		end else begin
			total = scfa_pkg::TOTAL_W'(req_s1.stored_usable_size)
				+ scfa_pkg::TOTAL_W'(scfa_pkg::HEADER_BYTES);
		end
		cls_d    = scfa_pkg::class_of(total);
		fill_sel = fill_q[cls_d];
		bytes_d  = scfa_pkg::heap_bytes_of(cls_d);

		status_d  = scfa_pkg::ST_OK;
		addr_ok_d = 1'b0;
		pop_d     = 1'b0;
		push_d    = 1'b0;
		bump_d    = 1'b0;
		hdr_d     = '0;
		cls_out_d = cls_d;
		slot_d    = fill_sel[scfa_pkg::STACK_W-1:0];

		if (req_s1.opcode == scfa_pkg::OP_ALLOC) begin
			if (total > scfa_pkg::MAX_BLOCK) begin
				status_d  = scfa_pkg::ST_TOO_LARGE;
				cls_out_d = '0;
			end else if (fill_sel != '0) begin
				// Reuse the most recently freed block of this class.
				pop_d     = 1'b1;
				addr_ok_d = 1'b1;
				hdr_d     = scfa_pkg::usable_of(cls_d);
				slot_d    = scfa_pkg::STACK_W'(fill_sel - scfa_pkg::FILL_W'(1));
			end else if (bump_q > heap_limit_q || bytes_d > heap_limit_q - bump_q) begin
				status_d = scfa_pkg::ST_OOM;
			end else begin
				// Fresh pages from the bump pointer.
				bump_d    = 1'b1;
				addr_ok_d = 1'b1;
				hdr_d     = scfa_pkg::usable_of(cls_d);
			end
		end else begin
			if (req_s1.block_address == '0) begin
				status_d  = scfa_pkg::ST_NULL_FREE;
				cls_out_d = '0;
			end else if (fill_sel >= scfa_pkg::FILL_W'(scfa_pkg::STACK_DEPTH)) begin
				status_d = scfa_pkg::ST_STACK_FULL;
			end else begin
				push_d = 1'b1;
			end
		end
		mem_addr = {cls_d, slot_d};
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_xfer) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_xfer) begin
			req_s1 <= req;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			status_s2  <= status_d;
			addr_ok_s2 <= addr_ok_d;
			pop_s2     <= pop_d;
			block_s2   <= bump_q;
			hdr_s2     <= hdr_d;
			cls_s2     <= cls_out_d;
		end
	end

	// Heap limit, bump pointer and per-class fill counts. A configuration
	// write to the heap start restarts the bump pointer there.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heap_limit_q <= scfa_pkg::HEAP_LIMIT_RST;
			bump_q       <= scfa_pkg::HEAP_START_RST;
			for (int i = 0; i < scfa_pkg::CLASS_COUNT; i++) begin
				fill_q[i] <= '0;
			end
		end else begin
			if (cfg_we && cfg_index == scfa_pkg::REG_HEAP_START) begin
				bump_q <= cfg_data;
			end else if (adv && bump_d) begin
				bump_q <= bump_q + bytes_d;
			end
			if (cfg_we && cfg_index == scfa_pkg::REG_HEAP_LIMIT) begin
				heap_limit_q <= cfg_data;
			end
			if (adv && pop_d) begin
				fill_q[cls_d] <= fill_sel - scfa_pkg::FILL_W'(1);
			end else if (adv && push_d) begin
				fill_q[cls_d] <= fill_sel + scfa_pkg::FILL_W'(1);
			end
		end
	end

	// Free block store: one port, a push writes and a pop reads.
	always_ff @(posedge clk) begin
		if (adv && push_d) begin
			store_mem[mem_addr] <= free_block;
		end
		if (adv && pop_d) begin
			rd_q <= store_mem[mem_addr];
		end
	end

	// Response fields. The block comes from the store on a pop and from the
	// captured bump pointer otherwise; failures and frees return address zero.
	always_comb begin
		resp_block        = pop_s2 ? rd_q : block_s2;
		rsp.status        = status_s2;
		rsp.user_address  = addr_ok_s2
			? resp_block + scfa_pkg::ADDR_W'(scfa_pkg::HEADER_BYTES) : '0;
		rsp.header_value  = hdr_s2;
		rsp.size_class    = cls_s2;
	end
	assign rsp_valid = valid_s2;

	// A fresh allocation moves the bump pointer by exactly its page bytes.
	`SCFA_ASSERT_NEXT(a_bump_step, adv && bump_d && !cfg_we, bump_q == $past(bump_q) + $past(bytes_d), "bump pointer did not advance by the page bytes")

	// A pop takes one entry off the selected class stack.
	`SCFA_ASSERT_NEXT(a_pop_count, adv && pop_d, fill_q[$past(cls_d)] == $past(fill_sel) - scfa_pkg::FILL_W'(1), "pop did not shrink the class stack")

	// A push adds one entry and never overfills a class stack.
	`SCFA_ASSERT_NEXT(a_push_count, adv && push_d, fill_q[$past(cls_d)] == $past(fill_sel) + scfa_pkg::FILL_W'(1) && fill_q[$past(cls_d)] <= scfa_pkg::FILL_W'(scfa_pkg::STACK_DEPTH), "push broke the class stack count")

	// Only a successful allocate returns an address.
	`SCFA_ASSERT_NOW(a_addr_ok, rsp_valid && addr_ok_s2, rsp.status == scfa_pkg::ST_OK, "address returned with a failure status")

endmodule

`default_nettype wire

// ----- tb/alloc_response_checker.sv -----
// Response checker for the size class free list allocator: it watches the request,
// response and register write channels, predicts every response and compares it.
// Depends on scfa_pkg for the payload structs, codes and sizing constants.
module alloc_response_checker (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            req_valid,
	input  wire                            req_stall,
	input  scfa_pkg::req_t                 req,
	input  wire                            rsp_valid,
	input  wire                            rsp_stall,
	input  scfa_pkg::rsp_t                 rsp,
	input  wire                            cfg_valid,
	input  wire                            cfg_ready,
	input  wire  [scfa_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire  [scfa_pkg::ADDR_W-1:0]    cfg_data,
	output int                             error_count,
	output int                             pending_count
);
	import scfa_pkg::*;

	// Shadow copy of the allocator state.
	logic [ADDR_W-1:0] freed_blocks [STORE_DEPTH];
	int unsigned       fill_level [CLASS_COUNT];
	logic [ADDR_W-1:0] limit_reg;
	logic [ADDR_W-1:0] bump_ptr;

	rsp_t awaited_rsps [$];
	rsp_t want;
	int   errs = 0;
	int   rsp_seen = 0;

	assign error_count = errs;

	task automatic report_mismatch(input string msg);
		$display("[%0t] response %0d: %s", $time, rsp_seen, msg);
		errs++;
	endtask

	// Smallest class whose block holds total bytes; anything bigger lands in the last class.
	function automatic logic [CLASS_W-1:0] fit_class(input logic [63:0] total);
		int c;
		c = 0;
		while (c < CLASS_COUNT - 1 && (64'(MIN_BLOCK) << c) < total) begin
			c++;
		end
		return CLASS_W'(c);
	endfunction

	function automatic rsp_t predict_response(input req_t r);
		rsp_t              o;
		logic [63:0]       total;
		logic [63:0]       bsz;
		logic [63:0]       span;
		logic [CLASS_W-1:0] c;
		logic [ADDR_W-1:0] blk;
		o = '0;
		o.status = ST_OK;
		if (r.opcode == OP_ALLOC) begin
			total = (r.request_size == '0) ? 64'd1 : 64'(r.request_size);
			total = total + 64'(HEADER_BYTES);
			if (total > (64'(MIN_BLOCK) << (CLASS_COUNT - 1))) begin
				o.status = ST_TOO_LARGE;
				return o;
			end
			c = fit_class(total);
			bsz = 64'(MIN_BLOCK) << c;
			if (fill_level[c] != 0) begin
				fill_level[c]--;
				blk = freed_blocks[int'(c) * STACK_DEPTH + int'(fill_level[c])];
			end else begin
				// A fresh block always takes whole pages from the bump pointer.
				span = ((bsz + 64'(PAGE_BYTES) - 1) / 64'(PAGE_BYTES)) * 64'(PAGE_BYTES);
				if (bump_ptr > limit_reg || span > 64'(limit_reg - bump_ptr)) begin
					o.status = ST_OOM;
					o.size_class = c;
					return o;
				end
				blk = bump_ptr;
				bump_ptr = ADDR_W'(64'(bump_ptr) + span);
			end
			o.user_address = blk + ADDR_W'(HEADER_BYTES);
			o.header_value = HDR_W'(bsz - 64'(HEADER_BYTES));
			o.size_class = c;
		end else begin
			if (r.block_address == '0) begin
				o.status = ST_NULL_FREE;
				return o;
			end
			blk = r.block_address - ADDR_W'(HEADER_BYTES);
			c = fit_class(64'(r.stored_usable_size) + 64'(HEADER_BYTES));
			o.size_class = c;
			if (fill_level[c] >= STACK_DEPTH) begin
				o.status = ST_STACK_FULL;
				return o;
			end
			freed_blocks[int'(c) * STACK_DEPTH + int'(fill_level[c])] = blk;
			fill_level[c]++;
		end
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (fill_level[i]) begin
				fill_level[i] = 0;
			end
			limit_reg = HEAP_LIMIT_RST;
			bump_ptr = HEAP_START_RST;
			awaited_rsps.delete();
			pending_count <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_HEAP_START) begin
					bump_ptr = cfg_data;
				end else begin
					limit_reg = cfg_data;
				end
			end
			if (rsp_valid && !rsp_stall) begin
				rsp_seen++;
				if (awaited_rsps.size() == 0) begin
					report_mismatch("response arrived with no request outstanding");
				end else begin
					want = awaited_rsps.pop_front();
					if (rsp.status !== want.status) begin
						report_mismatch($sformatf("status got %0d, wanted %0d",
							rsp.status, want.status));
					end
					if (rsp.user_address !== want.user_address) begin
						report_mismatch($sformatf("user_address got %h, wanted %h",
							rsp.user_address, want.user_address));
					end
					if (rsp.header_value !== want.header_value) begin
						report_mismatch($sformatf("header_value got %h, wanted %h",
							rsp.header_value, want.header_value));
					end
					if (rsp.size_class !== want.size_class) begin
						report_mismatch($sformatf("size_class got %0d, wanted %0d",
							rsp.size_class, want.size_class));
					end
				end
			end
			if (req_valid && !req_stall) begin
				awaited_rsps.push_back(predict_response(req));
			end
			pending_count <= awaited_rsps.size();
		end
	end

endmodule

// ----- tb/tb.sv -----
// Top of the allocator testbench: clock, reset, request and register stimulus,
// receiver stalls and the verdict. Depends on scfa_pkg, the allocator RTL and
// alloc_response_checker, which does all prediction and comparison.
module tb;
	import scfa_pkg::*;

	// Upper bound on the run; a correct run ends well before it.
	localparam int CYCLE_LIMIT = 200000;
	localparam int PHASE_ITEMS = 210;
	// Two more than a class stack holds, so a burst always ends in dropped frees.
	localparam int BURST_LEN   = STACK_DEPTH + 2;
	localparam int HOLD_CYCLES = 48;
	localparam int POOL_MAX    = 256;
	localparam int DRAIN_WAIT  = 8;
	localparam logic [ADDR_W-1:0] ADDR_MAX = '1;

	// A block handed out by the allocator, kept so that it can be freed later.
	typedef struct {
		logic [ADDR_W-1:0] addr;
		logic [HDR_W-1:0]  usable;
	} live_block_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 req_valid;
	logic                 req_stall;
	req_t                 req;
	logic                 rsp_valid;
	logic                 rsp_stall;
	rsp_t                 rsp;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [ADDR_W-1:0]    cfg_data;
	int                   error_count;
	int                   pending_count;

	// Idle rates in percent for the request sender and the response receiver.
	int send_idle_pct;
	int recv_idle_pct;
	// The stimulus bumps hold_requests; the receiver process notices the change and
	// then holds the stall while it counts hold_left down from HOLD_CYCLES.
	int hold_requests;
	int holds_served;
	int hold_left;
	int cycle_count;

	live_block_t live_blocks [$];

	size_class_free_list_allocator_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	alloc_response_checker resp_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.req_valid     (req_valid),
		.req_stall     (req_stall),
		.req           (req),
		.rsp_valid     (rsp_valid),
		.rsp_stall     (rsp_stall),
		.rsp           (rsp),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.error_count   (error_count),
		.pending_count (pending_count)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Receiver side. The stall changes only at the falling edge, so the block and
	// the checker both see a settled value at the rising edge.
	always @(negedge clk) begin
		if (hold_requests != holds_served) begin
			holds_served = hold_requests;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
		end
	end

	// Every successful allocation goes into the pool of live blocks, so that most
	// frees hand back real blocks with their real header values.
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall && rsp.status == ST_OK
			&& rsp.user_address != '0) begin
			live_blocks.push_back('{rsp.user_address, rsp.header_value});
			if (live_blocks.size() > POOL_MAX) begin
				void'(live_blocks.pop_front());
			end
		end
	end

	function automatic logic [ADDR_W-1:0] rand_addr();
		return ADDR_W'({$urandom(), $urandom()});
	endfunction

	// A nonzero user address; now and then one below the header size, which wraps.
	function automatic logic [ADDR_W-1:0] rand_user_addr();
		logic [ADDR_W-1:0] a;
		if ($urandom_range(0, 9) == 0) begin
			a = ADDR_W'($urandom_range(1, HEADER_BYTES - 1));
		end else begin
			a = rand_addr();
			if (a == '0) begin
				a = 1;
			end
		end
		return a;
	endfunction

	// Allocation sizes lean on the small classes, where stacks get reused often;
	// the rest covers the large classes, the boundaries and oversized requests.
	function automatic logic [SIZE_W-1:0] pick_alloc_size();
		int          pick;
		int          c;
		logic [63:0] lo;
		logic [63:0] hi;
		pick = $urandom_range(0, 99);
		if (pick < 80) begin
			c = (pick < 55) ? $urandom_range(1, 5) : $urandom_range(6, CLASS_COUNT - 1);
			lo = (64'(MIN_BLOCK) << (c - 1)) - 64'(HEADER_BYTES - 1);
			hi = (64'(MIN_BLOCK) << c) - 64'(HEADER_BYTES);
			return SIZE_W'(lo + 64'($urandom_range(0, int'(hi - lo))));
		end
		if (pick < 85) begin
			c = $urandom_range(1, CLASS_COUNT - 1);
			case ($urandom_range(0, 3))
				0: return '0;
				1: return SIZE_W'((64'(MIN_BLOCK) << c) - 64'(HEADER_BYTES));
				2: return SIZE_W'((64'(MIN_BLOCK) << c) - 64'(HEADER_BYTES - 1));
				default: return 1;
			endcase
		end
		if (pick < 93) begin
			return $urandom_range(32'd262137, 32'hFFFF_FFFF);
		end
		return $urandom();
	endfunction

	// Header values read back on a free: either any 18-bit value or a class size.
	function automatic logic [HDR_W-1:0] pick_usable();
		int c;
		if ($urandom_range(0, 1) == 0) begin
			return HDR_W'($urandom_range(0, 18'h3FFFF));
		end
		c = $urandom_range(0, CLASS_COUNT - 1);
		return HDR_W'((64'(MIN_BLOCK) << c) - 64'(HEADER_BYTES));
	endfunction

	// Offers one request and returns at the rising edge where it is taken. The
	// sender may idle first; a stalled request is held unchanged.
	task automatic send_req(input req_t r);
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		req <= r;
		@(posedge clk);
		while (req_stall) begin
			@(posedge clk);
		end
	endtask

	// Fields that an operation ignores carry random values, so their bits toggle too.
	task automatic send_alloc(input logic [SIZE_W-1:0] size);
		req_t r;
		r.opcode = OP_ALLOC;
		r.request_size = size;
		r.block_address = rand_addr();
		r.stored_usable_size = HDR_W'($urandom());
		send_req(r);
	endtask

	task automatic send_free(input logic [ADDR_W-1:0] addr, input logic [HDR_W-1:0] usable);
		req_t r;
		r.opcode = OP_FREE;
		r.request_size = $urandom();
		r.block_address = addr;
		r.stored_usable_size = usable;
		send_req(r);
	endtask

	// Stops offering requests and waits until every transfer has its response.
	// Each request yields exactly one response, so nothing is left in the block.
	task automatic wait_drained();
		@(negedge clk);
		req_valid <= 1'b0;
		while (pending_count != 0) begin
			@(posedge clk);
		end
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [ADDR_W-1:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) begin
			@(posedge clk);
		end
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Writing the start also reloads the bump pointer, so the heap starts empty.
	task automatic set_heap(input logic [ADDR_W-1:0] base, input logic [ADDR_W-1:0] limit);
		write_reg(REG_HEAP_LIMIT, limit);
		write_reg(REG_HEAP_START, base);
	endtask

	// Mostly frees of live blocks and allocations, with some stray and null frees.
	task automatic issue_random_item();
		int               pick;
		int               k;
		live_block_t      lb;
		logic [HDR_W-1:0] usable;
		pick = $urandom_range(0, 99);
		if (pick < 45) begin
			send_alloc(pick_alloc_size());
		end else if (pick < 82 && live_blocks.size() != 0) begin
			k = $urandom_range(0, live_blocks.size() - 1);
			lb = live_blocks[k];
			live_blocks.delete(k);
			// Now and then the header read back is corrupt.
			usable = ($urandom_range(0, 19) == 0) ? pick_usable() : lb.usable;
			send_free(lb.addr, usable);
		end else if (pick < 95) begin
			send_free(rand_user_addr(), pick_usable());
		end else begin
			send_free('0, pick_usable());
		end
	endtask

	// Frees more blocks into one small class than its stack can hold.
	task automatic issue_free_burst();
		int c;
		c = $urandom_range(0, 4);
		repeat (BURST_LEN) begin
			send_free(rand_user_addr(), HDR_W'((64'(MIN_BLOCK) << c) - 64'(HEADER_BYTES)));
		end
	endtask

	// One random phase on a small heap of random placement, so that the bump
	// pointer runs out and freed blocks must be reused. hold_at starts a long
	// receiver hold-off; pause_at lets the block drain completely.
	task automatic run_phase(input int send_pct, input int recv_pct,
		input int hold_at, input int pause_at);
		logic [63:0]       span;
		logic [ADDR_W-1:0] base;
		int                burst_at;
		span = 64'($urandom_range(6, 24)) * 64'(PAGE_BYTES) + 64'($urandom_range(0, 65535));
		base = rand_addr();
		if (64'(base) > 64'(ADDR_MAX) - span) begin
			base = ADDR_W'(64'(ADDR_MAX) - span);
		end
		wait_drained();
		set_heap(base, ADDR_W'(64'(base) + span));
		@(posedge clk);
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		burst_at = $urandom_range(0, PHASE_ITEMS - 1);
		for (int i = 0; i < PHASE_ITEMS; i++) begin
			if (i == burst_at) begin
				issue_free_burst();
			end
			if (i == hold_at) begin
				hold_requests++;
			end
			if (i == pause_at) begin
				wait_drained();
			end
			issue_random_item();
		end
	endtask

	// Watchdog: a hung handshake ends the run as a failure.
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("size_class_free_list_allocator_unit verification failed");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		rsp_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_requests = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed part on the reset heap. A zero size counts as one byte, the
		// largest class is exactly full at 262136 bytes and one byte more is too
		// large, as is the largest 32-bit size.
		send_alloc('0);
		send_alloc(1);
		send_alloc(8);
		send_alloc(9);
		send_alloc(32'd262136);
		send_alloc(32'd262137);
		send_alloc(32'hFFFF_FFFF);
		// A null free is ignored. A user address below the header size wraps
		// around the address space, and an oversized header clamps to the last class.
		send_free('0, 18'h3FFFF);
		send_free(1, '0);
		send_free(ADDR_MAX, 18'h3FFFF);
		// The next allocation of the last class pops the block just freed.
		send_alloc(32'd262136);
		// A free followed at once by an allocation of the same class.
		send_free(40'h00_0001_2340, 18'd24);
		send_alloc(20);
		send_free(40'hAA_AAAA_AAAA, 18'd262136);
		send_free(40'h55_5555_5555, 18'h1FFFF);

		// A heap of two pages: two fresh blocks fit, the third runs out of memory.
		wait_drained();
		set_heap('0, 40'h00_0002_0000);
		send_alloc(100);
		send_alloc(60000);
		send_alloc(10);
		// Bump pointer already beyond the limit.
		wait_drained();
		set_heap(ADDR_MAX, '0);
		send_alloc(5);
		// One byte short of a page at the very top of the address space.
		wait_drained();
		set_heap(40'hFF_FFFF_0000, ADDR_MAX);
		send_alloc(1);
		// An empty heap.
		wait_drained();
		set_heap(40'h00_0010_0000, 40'h00_0010_0000);
		send_alloc(300);
		// The whole address space.
		wait_drained();
		set_heap('0, ADDR_MAX);
		send_alloc(32'd262136);
		send_alloc(32'd131000);

		// Random phases: sender idles 37 percent and receiver 60, then the other
		// way round, then neither idles. The first and last phases include a long
		// receiver hold-off while requests keep coming; the second and last ones
		// pause the sender until the block has drained.
		run_phase(37, 60, 60, -1);
		run_phase(60, 37, -1, 150);
		run_phase(0, 0, 40, 200);

		wait_drained();
		repeat (DRAIN_WAIT) @(posedge clk);
		if (error_count == 0 && pending_count == 0) begin
			$display("size_class_free_list_allocator_unit verification clean");
		end else begin
			$display("size_class_free_list_allocator_unit verification failed");
		end
		$finish;
	end

endmodule
